>>> design/sfs_pkg.sv
// Package for the sprite frame sequencer: field widths, operation codes,
// register indexes and the sequencer state type.
// No dependencies; sfs_if and sprite_frame_sequencer use it by scoped names.
package sfs_pkg;

   localparam int OP_W        = 3;
   localparam int FIELD_W     = 24;
   localparam int INDEX_OUT_W = 6;
   localparam int MIN_W       = 20;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 20;

   localparam logic [MIN_W-1:0] MIN_RESET = 20'd1000;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLED = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DURATION = 1'd1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK         = 3'd0,
      OP_PLAY         = 3'd1,
      OP_PLAY_RESTART = 3'd2,
      OP_PAUSE        = 3'd3,
      OP_STOP         = 3'd4,
      OP_ADD_FRAME    = 3'd5,
      OP_SET_ALL      = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_ADD,
      ST_CMP,
      ST_WRAP,
      ST_MOD,
      ST_SWEEP,
      ST_APPEND,
      ST_DONE
   } state_type;

endpackage

>>> design/sfs_if.sv
// Valid/ready channel interfaces of the sprite frame sequencer.
// Depends on sfs_pkg for the field widths.
interface sfs_req_if;
   logic                          valid;
   logic                          ready;
   logic [sfs_pkg::OP_W-1:0]      op;
   logic [sfs_pkg::FIELD_W-1:0]   delta_time;
   logic [sfs_pkg::FIELD_W-1:0]   duration;

   modport source (output valid, output op, output delta_time, output duration,
                   input ready);
   modport sink (input valid, input op, input delta_time, input duration,
                 output ready);
endinterface

interface sfs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sfs_pkg::INDEX_OUT_W-1:0] frame_index;
   logic                            playing;
   logic                            finished;
   logic                            has_frames;
   logic                            rejected;

   modport source (output valid, output frame_index, output playing,
                   output finished, output has_frames, output rejected,
                   input ready);
   modport sink (input valid, input frame_index, input playing,
                 input finished, input has_frames, input rejected,
                 output ready);
endinterface

>>> design/sprite_frame_sequencer.sv
// Sprite frame sequencer: a table of per-frame durations in microseconds,
// stepped by tick words; one status word out for every request word in.
// Depends on sfs_pkg, sfs_if, sfs_ram and sfs_addsub.
//
// Usage: req_if carries op, delta_time and duration; rsp_if returns the
// frame index and status flags. csr_* writes loop_enabled (index 0) and
// min_duration (index 1); the user writes them only while the block is
// idle, which the block does not enforce. Play, pause, stop, unused codes,
// refused or empty operations and zero, paused or empty ticks go straight
// to the status word; add frame writes one entry; set all rewrites every
// stored entry. Other ticks add delta_time, step over each frame boundary
// crossed, wrap in looping mode, and reduce elapsed time of a whole
// sequence or more by a bit-serial remainder. Time and duration arithmetic
// uses the one shared add/subtract unit; the table is read one entry a cycle.
// One request word is in flight at a time: req_if.ready is high only
// while idle, and a new word may be taken while the previous status word
// still waits on rsp_if. A stalled receiver holds the next item at its end.
// Reset empties the table, stops playback and loads min_duration 1000.
module sprite_frame_sequencer #(
   parameter int MAX_FRAMES = 64,
   parameter int TIME_WIDTH = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   sfs_req_if.sink                          req_if,
   sfs_rsp_if.source                        rsp_if,
   input  logic                             csr_wr_en,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW   = $clog2(MAX_FRAMES + 1);
   localparam int DURW = (TIME_WIDTH > sfs_pkg::MIN_W) ? TIME_WIDTH : sfs_pkg::MIN_W;
   localparam int ETW  = ((DURW > sfs_pkg::FIELD_W) ? DURW : sfs_pkg::FIELD_W) + 1;
   localparam int SW   = DURW + CW;
   localparam int W    = (SW + 1 > ETW) ? SW + 1 : ETW;
   localparam int MCW  = $clog2(ETW + 1);

   sfs_pkg::state_type state_ff, state_in;

   logic [IW-1:0]                   idx_ff, idx_in;
   logic [CW-1:0]                   total_ff, total_in;
   logic [ETW-1:0]                  elapsed_ff, elapsed_in;
   logic [SW-1:0]                   sum_ff, sum_in;
   logic [SW-1:0]                   rem_ff, rem_in;
   logic [MCW-1:0]                  mod_cnt_ff, mod_cnt_in;
   logic [IW-1:0]                   sweep_ff, sweep_in;
   logic                            playing_ff, playing_in;
   logic                            finished_ff, finished_in;
   logic                            rej_ff, rej_in;
   logic [sfs_pkg::FIELD_W-1:0]     delta_ff, delta_in;
   logic [sfs_pkg::FIELD_W-1:0]     dur_ff, dur_in;
   logic                            loop_ff;
   logic [sfs_pkg::MIN_W-1:0]       min_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sfs_pkg::INDEX_OUT_W-1:0] rsp_index_ff;
   logic                            rsp_playing_ff;
   logic                            rsp_finished_ff;
   logic                            rsp_has_ff;
   logic                            rsp_rej_ff;

   logic                            req_accept;
   logic                            rsp_load;
   logic                            has_next;
   logic                            last_sweep;
   logic                            table_full;
   logic                            tick_live;
   logic [sfs_pkg::MIN_W-1:0]       min_eff;
   logic [DURW-1:0]                 dur_tw;
   logic [DURW-1:0]                 clamp_d;
   logic [SW:0]                     mod_t;
   logic [SW-1:0]                   rem_next;

   logic [W-1:0]                    alu_a, alu_b, alu_res;
   logic                            alu_sub, alu_carry;

   logic                            ram_we;
   logic [IW-1:0]                   ram_waddr;
   logic [DURW-1:0]                 ram_rdata;

   assign req_if.ready = (state_ff == sfs_pkg::ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_load     = (state_ff == sfs_pkg::ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   assign has_next   = ((CW+1)'(idx_ff) + (CW+1)'(1)) < (CW+1)'(total_ff);
   assign last_sweep = ((CW+1)'(sweep_ff) + (CW+1)'(1)) == (CW+1)'(total_ff);
   assign table_full = total_ff >= CW'(MAX_FRAMES);
   assign tick_live  = playing_ff && (total_ff != '0) && (req_if.delta_time != '0);

   assign min_eff = (min_ff == '0) ? sfs_pkg::MIN_W'(1) : min_ff;
   assign dur_tw  = DURW'(TIME_WIDTH'(dur_ff));
   assign clamp_d = (dur_tw < DURW'(min_eff)) ? DURW'(min_eff) : dur_tw;

   assign mod_t    = {rem_ff, elapsed_ff[ETW-1]};
   assign rem_next = alu_carry ? SW'(alu_res) : SW'(mod_t);

   sfs_addsub #(.W(W)) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .res   (alu_res),
      .carry (alu_carry)
   );

   sfs_ram #(.WIDTH(DURW), .DEPTH(MAX_FRAMES)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (clamp_d),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         sfs_pkg::ST_TICK_ADD: begin
            alu_a = W'(elapsed_ff);
            alu_b = W'(delta_ff);
         end
         sfs_pkg::ST_CMP: begin
            alu_a   = W'(elapsed_ff);
            alu_b   = W'(ram_rdata);
            alu_sub = 1'b1;
         end
         sfs_pkg::ST_WRAP: begin
            alu_a   = W'(elapsed_ff);
            alu_b   = W'(sum_ff);
            alu_sub = 1'b1;
         end
         sfs_pkg::ST_MOD: begin
            alu_a   = W'(mod_t);
            alu_b   = W'(sum_ff);
            alu_sub = 1'b1;
         end
         sfs_pkg::ST_SWEEP, sfs_pkg::ST_APPEND: begin
            alu_a = W'(sum_ff);
            alu_b = W'(clamp_d);
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfs_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (sfs_pkg::op_type'(req_if.op))
                  sfs_pkg::OP_TICK:
                     state_in = tick_live ? sfs_pkg::ST_TICK_ADD : sfs_pkg::ST_DONE;
                  sfs_pkg::OP_ADD_FRAME:
                     state_in = table_full ? sfs_pkg::ST_DONE : sfs_pkg::ST_APPEND;
                  sfs_pkg::OP_SET_ALL:
                     state_in = (total_ff != '0) ? sfs_pkg::ST_SWEEP : sfs_pkg::ST_DONE;
                  default:
                     state_in = sfs_pkg::ST_DONE;
               endcase
            end
         end
         sfs_pkg::ST_TICK_ADD: state_in = sfs_pkg::ST_CMP;
         sfs_pkg::ST_CMP: begin
            priority if (!alu_carry) begin
               state_in = sfs_pkg::ST_DONE;
            end else if (has_next) begin
               state_in = sfs_pkg::ST_CMP;
            end else if (loop_ff) begin
               state_in = sfs_pkg::ST_WRAP;
            end else begin
               state_in = sfs_pkg::ST_DONE;
            end
         end
         sfs_pkg::ST_WRAP: state_in = alu_carry ? sfs_pkg::ST_MOD : sfs_pkg::ST_CMP;
         sfs_pkg::ST_MOD: begin
            if (mod_cnt_ff == MCW'(ETW - 1)) begin
               state_in = sfs_pkg::ST_CMP;
            end
         end
         sfs_pkg::ST_SWEEP: begin
            if (last_sweep) begin
               state_in = sfs_pkg::ST_DONE;
            end
         end
         sfs_pkg::ST_APPEND: state_in = sfs_pkg::ST_DONE;
         sfs_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = sfs_pkg::ST_IDLE;
            end
         end
         default: state_in = sfs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in      = idx_ff;
      total_in    = total_ff;
      elapsed_in  = elapsed_ff;
      sum_in      = sum_ff;
      rem_in      = rem_ff;
      mod_cnt_in  = mod_cnt_ff;
      sweep_in    = sweep_ff;
      playing_in  = playing_ff;
      finished_in = finished_ff;
      rej_in      = rej_ff;
      delta_in    = delta_ff;
      dur_in      = dur_ff;
      ram_we      = 1'b0;
      ram_waddr   = IW'(total_ff);
      unique case (state_ff)
         sfs_pkg::ST_IDLE: begin
            if (req_accept) begin
               rej_in   = 1'b0;
               delta_in = req_if.delta_time;
               dur_in   = req_if.duration;
               unique case (sfs_pkg::op_type'(req_if.op))
                  sfs_pkg::OP_PLAY: begin
                     playing_in  = 1'b1;
                     finished_in = 1'b0;
                  end
                  sfs_pkg::OP_PLAY_RESTART: begin
                     idx_in      = '0;
                     elapsed_in  = '0;
                     playing_in  = 1'b1;
                     finished_in = 1'b0;
                  end
                  sfs_pkg::OP_PAUSE: playing_in = 1'b0;
                  sfs_pkg::OP_STOP: begin
                     idx_in      = '0;
                     elapsed_in  = '0;
                     playing_in  = 1'b0;
                     finished_in = 1'b0;
                  end
                  sfs_pkg::OP_ADD_FRAME: rej_in = table_full;
                  sfs_pkg::OP_SET_ALL: begin
                     sweep_in = '0;
                     if (total_ff != '0) begin
                        sum_in = '0;
                     end
                  end
                  default: rej_in = 1'b0;
               endcase
            end
         end
         sfs_pkg::ST_TICK_ADD: elapsed_in = ETW'(alu_res);
         sfs_pkg::ST_CMP: begin
            if (alu_carry) begin
               elapsed_in = ETW'(alu_res);
               priority if (has_next) begin
                  idx_in = idx_ff + IW'(1);
               end else if (loop_ff) begin
                  idx_in = '0;
               end else begin
                  elapsed_in  = '0;
                  playing_in  = 1'b0;
                  finished_in = 1'b1;
               end
            end
         end
         sfs_pkg::ST_WRAP: begin
            rem_in     = '0;
            mod_cnt_in = '0;
         end
         sfs_pkg::ST_MOD: begin
            rem_in     = rem_next;
            mod_cnt_in = mod_cnt_ff + MCW'(1);
            elapsed_in = elapsed_ff << 1;
            if (mod_cnt_ff == MCW'(ETW - 1)) begin
               elapsed_in = ETW'(rem_next);
            end
         end
         sfs_pkg::ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            sum_in    = SW'(alu_res);
            sweep_in  = sweep_ff + IW'(1);
         end
         sfs_pkg::ST_APPEND: begin
            ram_we   = 1'b1;
            sum_in   = SW'(alu_res);
            total_in = total_ff + CW'(1);
            if (total_ff == '0) begin
               idx_in      = '0;
               elapsed_in  = '0;
               finished_in = 1'b0;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_if.ready) || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfs_pkg::ST_IDLE;
         idx_ff       <= '0;
         total_ff     <= '0;
         elapsed_ff   <= '0;
         sum_ff       <= '0;
         playing_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         rej_ff       <= 1'b0;
         loop_ff      <= 1'b0;
         min_ff       <= sfs_pkg::MIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         elapsed_ff   <= elapsed_in;
         sum_ff       <= sum_in;
         playing_ff   <= playing_in;
         finished_ff  <= finished_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && (csr_index == sfs_pkg::CSR_LOOP_ENABLED)) begin
            loop_ff <= csr_wdata[0];
         end
         if (csr_wr_en && (csr_index == sfs_pkg::CSR_MIN_DURATION)) begin
            min_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      mod_cnt_ff <= mod_cnt_in;
      sweep_ff   <= sweep_in;
      delta_ff   <= delta_in;
      dur_ff     <= dur_in;
      if (rsp_load) begin
         rsp_index_ff    <= sfs_pkg::INDEX_OUT_W'(idx_ff);
         rsp_playing_ff  <= playing_ff;
         rsp_finished_ff <= finished_ff;
         rsp_has_ff      <= (total_ff != '0);
         rsp_rej_ff      <= rej_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.frame_index = rsp_index_ff;
   assign rsp_if.playing     = rsp_playing_ff;
   assign rsp_if.finished    = rsp_finished_ff;
   assign rsp_if.has_frames  = rsp_has_ff;
   assign rsp_if.rejected    = rsp_rej_ff;

   a_idx_in_table: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) |-> ((CW+1)'(idx_ff) < (CW+1)'(total_ff)))
      else $error("frame index beyond stored frames");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(MAX_FRAMES))
      else $error("frame total beyond table depth");

   a_play_fin_excl: assert property (@(posedge clock) disable iff (reset)
      !(playing_ff && finished_ff))
      else $error("playing and finished both set");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_if.ready)
      else $error("request taken while a word is in flight");

endmodule

>>> design/sfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sfs_addsub.sv
// Shared add/subtract unit of the sprite frame sequencer.
// Carry out high on a subtract means no borrow. No dependencies.
module sfs_addsub #(
   parameter int W = 32
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         sub,
   output logic [W-1:0] res,
   output logic         carry
);

   logic [W-1:0] b_eff;

   assign b_eff = sub ? ~b : b;
   assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + (W+1)'(sub);

endmodule
